// File: src/rgbsls_pkg.sv
// Shared types, command codes and constants for the RGB status LED sequencer.
package rgbsls_pkg;

    // Request kinds
    localparam logic [2:0] KIND_TICK          = 3'd0;
    localparam logic [2:0] KIND_SET_CALL      = 3'd1;
    localparam logic [2:0] KIND_CLEAR_CALL    = 3'd2;
    localparam logic [2:0] KIND_SET_CAPTURE   = 3'd3;
    localparam logic [2:0] KIND_CLEAR_CAPTURE = 3'd4;
    localparam logic [2:0] KIND_SET_ERROR     = 3'd5;
    localparam logic [2:0] KIND_SET_CUSTOM    = 3'd6;
    localparam logic [2:0] KIND_CLEAR_CUSTOM  = 3'd7;

    // Error levels
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LOW  = 2'd1;
    localparam logic [1:0] ERR_MID  = 2'd2;
    localparam logic [1:0] ERR_HIGH = 2'd3;

    // Custom blink targets
    localparam logic [1:0] TGT_RED   = 2'd0;
    localparam logic [1:0] TGT_BLUE  = 2'd1;
    localparam logic [1:0] TGT_GREEN = 2'd2;
    localparam logic [1:0] TGT_NONE  = 2'd3;

    // Bit positions in the LED level vector
    localparam logic [1:0] LED_RED_BIT   = 2'd0;
    localparam logic [1:0] LED_GREEN_BIT = 2'd1;
    localparam logic [1:0] LED_BLUE_BIT  = 2'd2;

    // Rotation phase codes: which LED lights at the next step
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_BLUE  = 2'd1;
    localparam logic [1:0] PH_GREEN = 2'd2;
    localparam logic [1:0] PH_STUCK = 2'd3;

    // Blink delays in milliseconds
    localparam logic [15:0] CAPTURE_DELAY_MS  = 16'd500;
    localparam logic [15:0] ERR_HIGH_DELAY_MS = 16'd200;
    localparam logic [15:0] ERR_MID_DELAY_MS  = 16'd1000;
    localparam logic [15:0] ERR_LOW_DELAY_MS  = 16'd2000;

    // Register indexes
    localparam logic [1:0] REG_SEQ_DELAY     = 2'd0;
    localparam logic [1:0] REG_CUSTOM_LED    = 2'd1;
    localparam logic [1:0] REG_CUSTOM_RATE   = 2'd2;
    localparam logic [1:0] REG_CUSTOM_TOGGLE = 2'd3;

    localparam logic [15:0] SEQ_DELAY_RESET = 16'd500;

    typedef struct packed {
        logic [15:0] sequence_delay_ms;
        logic [1:0]  custom_led;
        logic [15:0] custom_rate_ms;
        logic [15:0] custom_toggles;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] error_level;
    } cmd_t;

    function automatic logic [1:0] tgt_to_bit(input logic [1:0] tgt);
        logic [1:0] idx;
        case (tgt)
            TGT_RED:   idx = LED_RED_BIT;
            TGT_BLUE:  idx = LED_BLUE_BIT;
            default:   idx = LED_GREEN_BIT;
        endcase
        return idx;
    endfunction

    function automatic logic [15:0] err_delay(input logic [1:0] level);
        logic [15:0] d;
        case (level)
            ERR_HIGH: d = ERR_HIGH_DELAY_MS;
            ERR_MID:  d = ERR_MID_DELAY_MS;
            default:  d = ERR_LOW_DELAY_MS;
        endcase
        return d;
    endfunction

endpackage

// File: src/rgb_status_led_sequencer.sv
// Top level: request register, mode core, result register and APB registers.
// Request register, then result register: the latter holds the LED levels shown on m_*.
// Throughput: one request per cycle unless m_ready stalls; the request register drains into
// the result register whenever that register is empty or being taken, so both sides overlap.
// Timing: the longest path runs through a TIME_BITS-wide subtract and compare in the core.
// Reset: aresetn is synchronous and active low; it empties both registers, clears all
// mode state and time to zero, and loads the configuration reset values.
module rgb_status_led_sequencer import rgbsls_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [1:0]  s_error_level,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_red_on,
    output logic        m_green_on,
    output logic        m_blue_on,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_valid_reg;
    cmd_t       cmd_reg;
    logic       out_valid_reg;
    logic [2:0] leds_reg;
    logic       advance;
    logic [2:0] led_next;
    cfg_t       cfg;

    // Advance the held request into the core when the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Capture the payload with each accepted request; hold it otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.kind        <= s_kind;
            cmd_reg.error_level <= s_error_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            leds_reg <= led_next;
        end
    end

    rgbsls_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgbsls_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .cmd      (cmd_reg),
        .cfg      (cfg),
        .led_next (led_next)
    );

    assign m_valid    = out_valid_reg;
    assign m_red_on   = leds_reg[LED_RED_BIT];
    assign m_green_on = leds_reg[LED_GREEN_BIT];
    assign m_blue_on  = leds_reg[LED_BLUE_BIT];

    held_request_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(cmd_reg)))
        else $error("stalled request lost or changed");

    result_from_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without a request advancing");

endmodule

// File: src/rgbsls_cfg.sv
// APB register file holding the sequencer configuration.
module rgbsls_cfg import rgbsls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_SEQ_DELAY:     cfg_next.sequence_delay_ms = pwdata[15:0];
                REG_CUSTOM_LED:    cfg_next.custom_led        = pwdata[1:0];
                REG_CUSTOM_RATE:   cfg_next.custom_rate_ms    = pwdata[15:0];
                REG_CUSTOM_TOGGLE: cfg_next.custom_toggles    = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sequence_delay_ms <= SEQ_DELAY_RESET;
            cfg_reg.custom_led        <= TGT_NONE;
            cfg_reg.custom_rate_ms    <= '0;
            cfg_reg.custom_toggles    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_SEQ_DELAY:     prdata[15:0] = cfg_reg.sequence_delay_ms;
            REG_CUSTOM_LED:    prdata[1:0]  = cfg_reg.custom_led;
            REG_CUSTOM_RATE:   prdata[15:0] = cfg_reg.custom_rate_ms;
            REG_CUSTOM_TOGGLE: prdata[15:0] = cfg_reg.custom_toggles;
            default: ;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: src/rgbsls_core.sv
// Mode state and single-pass next-state logic for one tick or command.
module rgbsls_core import rgbsls_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  cmd_t       cmd,
    input  cfg_t       cfg,
    output logic [2:0] led_next
);

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] shared_stamp_reg, shared_stamp_next;
    logic [TIME_BITS-1:0] custom_stamp_reg, custom_stamp_next;
    logic [1:0]  rotation_phase_reg, rotation_phase_next;
    logic        call_active_reg, call_active_next;
    logic        capture_active_reg, capture_active_next;
    logic        custom_active_reg, custom_active_next;
    logic [1:0]  error_level_reg, error_level_next;
    logic        capture_phase_reg, capture_phase_next;
    logic        error_phase_reg, error_phase_next;
    logic        custom_phase_reg, custom_phase_next;
    logic [15:0] toggles_done_reg, toggles_done_next;
    logic [2:0]  led_levels_reg, led_levels_next;

    logic [TIME_BITS-1:0] now_inc;
    logic [TIME_BITS-1:0] el_shared;
    logic [TIME_BITS-1:0] el_custom;
    logic                 rot_fire;
    logic                 cap_fire;

    assign now_inc   = now_reg + 1'b1;
    assign el_shared = now_inc - shared_stamp_reg;
    assign el_custom = now_inc - custom_stamp_reg;

    always_comb begin
        now_next            = now_reg;
        shared_stamp_next   = shared_stamp_reg;
        custom_stamp_next   = custom_stamp_reg;
        rotation_phase_next = rotation_phase_reg;
        call_active_next    = call_active_reg;
        capture_active_next = capture_active_reg;
        custom_active_next  = custom_active_reg;
        error_level_next    = error_level_reg;
        capture_phase_next  = capture_phase_reg;
        error_phase_next    = error_phase_reg;
        custom_phase_next   = custom_phase_reg;
        toggles_done_next   = toggles_done_reg;
        led_levels_next     = led_levels_reg;
        rot_fire            = 1'b0;
        cap_fire            = 1'b0;

        if (step_en) begin
            unique case (cmd.kind)
                KIND_TICK: begin
                    now_next = now_inc;

                    // Rotation; a firing step restamps and keeps the later shared modes from firing this tick
                    if (call_active_reg && rotation_phase_reg != PH_STUCK &&
                        el_shared > TIME_BITS'(cfg.sequence_delay_ms)) begin
                        rot_fire          = 1'b1;
                        shared_stamp_next = now_inc;
                        led_levels_next   = '0;
                        case (rotation_phase_reg)
                            PH_RED: begin
                                led_levels_next[LED_RED_BIT] = 1'b1;
                                rotation_phase_next          = PH_BLUE;
                            end
                            PH_BLUE: begin
                                led_levels_next[LED_BLUE_BIT] = 1'b1;
                                rotation_phase_next           = PH_GREEN;
                            end
                            default: begin
                                led_levels_next[LED_GREEN_BIT] = 1'b1;
                                rotation_phase_next            = PH_RED;
                            end
                        endcase
                    end

                    if (capture_active_reg && !rot_fire &&
                        el_shared > TIME_BITS'(CAPTURE_DELAY_MS)) begin
                        cap_fire                       = 1'b1;
                        led_levels_next[LED_GREEN_BIT] = capture_phase_reg;
                        capture_phase_next             = ~capture_phase_reg;
                        shared_stamp_next              = now_inc;
                    end

                    if (error_level_reg == ERR_NONE) begin
                        if (error_phase_reg) begin
                            error_phase_next             = 1'b0;
                            led_levels_next[LED_RED_BIT] = 1'b0;
                        end
                    end else if (!rot_fire && !cap_fire &&
                                 el_shared > TIME_BITS'(err_delay(error_level_reg))) begin
                        led_levels_next[LED_RED_BIT] = error_phase_reg;
                        error_phase_next             = ~error_phase_reg;
                        shared_stamp_next            = now_inc;
                    end

                    if (custom_active_reg) begin
                        if (cfg.custom_led == TGT_NONE) begin
                            toggles_done_next = '0;
                            custom_phase_next = 1'b0;
                        end else if (el_custom > TIME_BITS'(cfg.custom_rate_ms) &&
                                     toggles_done_reg < cfg.custom_toggles) begin
                            led_levels_next[tgt_to_bit(cfg.custom_led)] = custom_phase_reg;
                            custom_phase_next = ~custom_phase_reg;
                            toggles_done_next = toggles_done_reg + 16'd1;
                            custom_stamp_next = now_inc;
                        end
                    end
                end
                KIND_SET_CALL:   call_active_next = 1'b1;
                KIND_CLEAR_CALL: begin
                    call_active_next = 1'b0;
                    led_levels_next  = '0;
                end
                KIND_SET_CAPTURE:   capture_active_next = 1'b1;
                KIND_CLEAR_CAPTURE: begin
                    capture_active_next = 1'b0;
                    led_levels_next     = '0;
                end
                KIND_SET_ERROR:  error_level_next   = cmd.error_level;
                KIND_SET_CUSTOM: custom_active_next = 1'b1;
                KIND_CLEAR_CUSTOM: begin
                    custom_active_next = 1'b0;
                    led_levels_next    = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg            <= '0;
            shared_stamp_reg   <= '0;
            custom_stamp_reg   <= '0;
            rotation_phase_reg <= PH_RED;
            call_active_reg    <= 1'b0;
            capture_active_reg <= 1'b0;
            custom_active_reg  <= 1'b0;
            error_level_reg    <= ERR_NONE;
            capture_phase_reg  <= 1'b0;
            error_phase_reg    <= 1'b0;
            custom_phase_reg   <= 1'b0;
            toggles_done_reg   <= '0;
            led_levels_reg     <= '0;
        end else begin
            now_reg            <= now_next;
            shared_stamp_reg   <= shared_stamp_next;
            custom_stamp_reg   <= custom_stamp_next;
            rotation_phase_reg <= rotation_phase_next;
            call_active_reg    <= call_active_next;
            capture_active_reg <= capture_active_next;
            custom_active_reg  <= custom_active_next;
            error_level_reg    <= error_level_next;
            capture_phase_reg  <= capture_phase_next;
            error_phase_reg    <= error_phase_next;
            custom_phase_reg   <= custom_phase_next;
            toggles_done_reg   <= toggles_done_next;
            led_levels_reg     <= led_levels_next;
        end
    end

    assign led_next = led_levels_next;

    rotation_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        rotation_phase_reg != PH_STUCK)
        else $error("rotation phase reached unused code");

    toggle_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (toggles_done_reg != $past(toggles_done_reg)) |->
            (toggles_done_reg == 16'($past(toggles_done_reg) + 16'd1) ||
             toggles_done_reg == 16'd0))
        else $error("custom toggle count jumped");

endmodule

// File: test/rgb_status_led_sequencer_tb.sv
// Self-checking testbench for the RGB status LED sequencer: requests in, LED levels checked.
module rgb_status_led_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbsls_pkg::*;

    // Run the block at its narrowest millisecond counter.
    localparam int TIME_BITS    = 16;
    localparam int IDLE_PCT     = 13;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_REQS   = 160;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } leds_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_kind;
    logic [1:0]  s_error_level;
    logic        m_valid;
    logic        m_ready;
    logic        m_red_on;
    logic        m_green_on;
    logic        m_blue_on;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Requests waiting for the driver, and LED levels waiting for the monitor.
    cmd_t  pending_reqs[$];
    leds_t expected_leds[$];

    // Shadow of the sequencer: configuration, clock, stamps and mode state.
    cfg_t                 led_cfg;
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] shared_stamp;
    logic [TIME_BITS-1:0] custom_stamp;
    logic [1:0]           rot_phase;
    logic                 call_on;
    logic                 capture_on;
    logic                 custom_on;
    logic [1:0]           err_level;
    logic                 capture_phase;
    logic                 error_phase;
    logic                 custom_phase;
    logic [15:0]          toggles_done;
    logic [2:0]           levels;

    int fail_count;
    bit no_idle;
    bit req_taken;

    rgb_status_led_sequencer #(
        .TIME_BITS(TIME_BITS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_error_level (s_error_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_on      (m_red_on),
        .m_green_on    (m_green_on),
        .m_blue_on     (m_blue_on),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // A step fires once the modular time since its stamp strictly exceeds the delay.
    function automatic bit time_over(input logic [TIME_BITS-1:0] stamp,
                                     input logic [15:0] limit);
        logic [TIME_BITS-1:0] gap;
        gap = now_ms - stamp;
        return gap > limit;
    endfunction

    task automatic reset_shadow();
        led_cfg       = '{sequence_delay_ms: SEQ_DELAY_RESET, custom_led: TGT_NONE,
                          custom_rate_ms: 16'd0, custom_toggles: 16'd0};
        now_ms        = '0;
        shared_stamp  = '0;
        custom_stamp  = '0;
        rot_phase     = PH_RED;
        call_on       = 1'b0;
        capture_on    = 1'b0;
        custom_on     = 1'b0;
        err_level     = ERR_NONE;
        capture_phase = 1'b0;
        error_phase   = 1'b0;
        custom_phase  = 1'b0;
        toggles_done  = 16'd0;
        levels        = 3'b000;
    endtask

    // Apply one request to the shadow state and return the LED levels it leaves behind.
    task automatic advance_leds(input cmd_t req, output leds_t result);
        logic [15:0] err_wait;
        logic [1:0]  tgt_bit;
        case (req.kind)
            KIND_TICK: begin
                now_ms = now_ms + 1'b1;
                // Calling: exactly one LED lit per step, red then blue then green.
                if (call_on && time_over(shared_stamp, led_cfg.sequence_delay_ms) &&
                    rot_phase != PH_STUCK) begin
                    levels = 3'b000;
                    case (rot_phase)
                        PH_RED: begin
                            levels[LED_RED_BIT] = 1'b1;
                            rot_phase = PH_BLUE;
                        end
                        PH_BLUE: begin
                            levels[LED_BLUE_BIT] = 1'b1;
                            rot_phase = PH_GREEN;
                        end
                        default: begin
                            levels[LED_GREEN_BIT] = 1'b1;
                            rot_phase = PH_RED;
                        end
                    endcase
                    shared_stamp = now_ms;
                end
                // Capture: green toggles on the shared stamp.
                if (capture_on && time_over(shared_stamp, CAPTURE_DELAY_MS)) begin
                    levels[LED_GREEN_BIT] = capture_phase;
                    capture_phase = ~capture_phase;
                    shared_stamp = now_ms;
                end
                // Error: no level drops red only if the blink phase was left set.
                if (err_level == ERR_NONE) begin
                    if (error_phase) begin
                        error_phase = 1'b0;
                        levels[LED_RED_BIT] = 1'b0;
                    end
                end else begin
                    if (err_level == ERR_HIGH) begin
                        err_wait = ERR_HIGH_DELAY_MS;
                    end else if (err_level == ERR_MID) begin
                        err_wait = ERR_MID_DELAY_MS;
                    end else begin
                        err_wait = ERR_LOW_DELAY_MS;
                    end
                    if (time_over(shared_stamp, err_wait)) begin
                        levels[LED_RED_BIT] = error_phase;
                        error_phase = ~error_phase;
                        shared_stamp = now_ms;
                    end
                end
                // Custom: no target clears the count; otherwise toggle until the count is hit.
                if (custom_on) begin
                    if (led_cfg.custom_led == TGT_NONE) begin
                        toggles_done = 16'd0;
                        custom_phase = 1'b0;
                    end else if (time_over(custom_stamp, led_cfg.custom_rate_ms) &&
                                 toggles_done < led_cfg.custom_toggles) begin
                        case (led_cfg.custom_led)
                            TGT_RED:  tgt_bit = LED_RED_BIT;
                            TGT_BLUE: tgt_bit = LED_BLUE_BIT;
                            default:  tgt_bit = LED_GREEN_BIT;
                        endcase
                        levels[tgt_bit] = custom_phase;
                        custom_phase = ~custom_phase;
                        toggles_done = toggles_done + 16'd1;
                        custom_stamp = now_ms;
                    end
                end
            end
            KIND_SET_CALL: call_on = 1'b1;
            KIND_CLEAR_CALL: begin
                call_on = 1'b0;
                levels  = 3'b000;
            end
            KIND_SET_CAPTURE: capture_on = 1'b1;
            KIND_CLEAR_CAPTURE: begin
                capture_on = 1'b0;
                levels     = 3'b000;
            end
            KIND_SET_ERROR: err_level = req.error_level;
            KIND_SET_CUSTOM: custom_on = 1'b1;
            default: begin
                custom_on = 1'b0;
                levels    = 3'b000;
            end
        endcase
        result.red   = levels[LED_RED_BIT];
        result.green = levels[LED_GREEN_BIT];
        result.blue  = levels[LED_BLUE_BIT];
    endtask

    task automatic check_led(input string led_name, input logic want, input logic got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s expected %0b, actual %0b", $time, led_name, want, got);
        end
    endtask

    // Driver: present a new request at the falling edge once the previous one was taken.
    always @(negedge aclk) begin
        cmd_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                req = pending_reqs.pop_front();
                s_valid       <= 1'b1;
                s_kind        <= req.kind;
                s_error_level <= req.error_level;
            end else begin
                s_valid <= 1'b0;
            end
        end
        // Stall the result side at random, except during the no-idle stretch.
        m_ready <= aresetn && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on each accepted request, then compare each accepted result.
    always @(posedge aclk) begin
        cmd_t  req;
        leds_t want;
        leds_t got;
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                req.kind        = s_kind;
                req.error_level = s_error_level;
                advance_leds(req, want);
                expected_leds.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = '{red: m_red_on, green: m_green_on, blue: m_blue_on};
                if (expected_leds.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result with none expected, actual r%0b g%0b b%0b",
                             $time, got.red, got.green, got.blue);
                end else begin
                    want = expected_leds.pop_front();
                    check_led("red_on", want.red, got.red);
                    check_led("green_on", want.green, got.green);
                    check_led("blue_on", want.blue, got.blue);
                end
            end
        end
    end

    task automatic push_req(input logic [2:0] kind, input logic [1:0] level);
        pending_reqs.push_back(cmd_t'{kind: kind, error_level: level});
    endtask

    // Hold until every request is out and every result is back, then let the pipe settle.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_leds.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready; junk above the width is dropped.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_SEQ_DELAY:   led_cfg.sequence_delay_ms = value[15:0];
            REG_CUSTOM_LED:  led_cfg.custom_led        = value[1:0];
            REG_CUSTOM_RATE: led_cfg.custom_rate_ms    = value[15:0];
            default:         led_cfg.custom_toggles    = value[15:0];
        endcase
    endtask

    task automatic write_config(input logic [15:0] delay, input logic [1:0] tgt,
                                input logic [15:0] rate, input logic [15:0] toggles);
        write_reg(REG_SEQ_DELAY,     (32'($urandom) << 16) | 32'(delay));
        write_reg(REG_CUSTOM_LED,    (32'($urandom) << 2) | 32'(tgt));
        write_reg(REG_CUSTOM_RATE,   (32'($urandom) << 16) | 32'(rate));
        write_reg(REG_CUSTOM_TOGGLE, (32'($urandom) << 16) | 32'(toggles));
    endtask

    // Mostly ticks so the timers fire; commands sprinkled in at the given rate.
    task automatic queue_random(input int count, input int cmd_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < cmd_pct)
                push_req(3'($urandom_range(7, 1)), 2'($urandom_range(3)));
            else
                push_req(KIND_TICK, 2'($urandom_range(3)));
        end
    endtask

    initial begin
        logic [15:0] delay;
        logic [15:0] rate;
        logic [15:0] toggles;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = KIND_TICK;
        s_error_level = ERR_NONE;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fail_count    = 0;
        no_idle       = 1'b0;
        req_taken     = 1'b0;
        reset_shadow();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: fast rotation, two-toggle blue custom blink.
        write_config(16'd0, TGT_BLUE, 16'd1, 16'd2);
        push_req(KIND_SET_CALL, ERR_NONE);
        push_req(KIND_TICK, ERR_HIGH);
        push_req(KIND_TICK, ERR_NONE);
        push_req(KIND_TICK, ERR_NONE);
        push_req(KIND_TICK, ERR_NONE);
        push_req(KIND_CLEAR_CALL, ERR_HIGH);
        push_req(KIND_SET_CAPTURE, ERR_NONE);
        push_req(KIND_TICK, ERR_NONE);
        push_req(KIND_CLEAR_CAPTURE, ERR_NONE);
        push_req(KIND_SET_ERROR, ERR_HIGH);
        push_req(KIND_SET_ERROR, ERR_MID);
        push_req(KIND_SET_ERROR, ERR_LOW);
        push_req(KIND_SET_ERROR, ERR_NONE);
        push_req(KIND_TICK, ERR_NONE);
        push_req(KIND_SET_CUSTOM, ERR_NONE);
        // Run past the toggle count so the blink stops.
        repeat (5) push_req(KIND_TICK, ERR_NONE);
        push_req(KIND_CLEAR_CUSTOM, ERR_NONE);
        wait_drained();

        // Directed: no custom target clears the spent count.
        write_reg(REG_CUSTOM_LED, 32'(TGT_NONE));
        push_req(KIND_SET_CUSTOM, ERR_NONE);
        push_req(KIND_TICK, ERR_NONE);
        push_req(KIND_TICK, ERR_LOW);
        wait_drained();

        // Random phases, each under its own register setting; the first two are the extremes.
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                write_config(16'hFFFF, TGT_NONE, 16'hFFFF, 16'hFFFF);
            end else if (p == 1) begin
                write_config(16'd0, TGT_RED, 16'd0, 16'd0);
            end else begin
                case ($urandom_range(3))
                    0:       delay = 16'($urandom_range(150, 600));
                    1:       delay = 16'hFFFF;
                    default: delay = 16'($urandom_range(30));
                endcase
                rate    = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(20));
                toggles = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(15));
                write_config(delay, 2'($urandom_range(3)), rate, toggles);
            end
            // Drop idling on both sides for one whole phase.
            no_idle = (p == 3);
            queue_random(PHASE_REQS, 10);
            wait_drained();
        end
        no_idle = 1'b0;

        // Longer run with call, custom blink and error modes in play at once.
        write_config(16'd70, TGT_GREEN, 16'd3, 16'hFFFF);
        push_req(KIND_SET_CALL, ERR_NONE);
        push_req(KIND_SET_CUSTOM, ERR_NONE);
        push_req(KIND_SET_ERROR, ERR_HIGH);
        queue_random(250, 1);
        wait_drained();

        if (fail_count == 0) begin
            $display("rgb_status_led_sequencer regression: pass");
        end else begin
            $display("rgb_status_led_sequencer regression: fail");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #4_000_000;
        $display("rgb_status_led_sequencer regression: fail");
        $finish;
    end

endmodule

// File: files.f
src/rgbsls_pkg.sv
src/rgbsls_cfg.sv
src/rgbsls_core.sv
src/rgb_status_led_sequencer.sv
test/rgb_status_led_sequencer_tb.sv
